/* design/meab_pkg.sv */
// Package: shared constants and types of the mesh edge adjacency builder.
`default_nettype none
package meab_pkg;
   localparam int SHAPE_W  = 4;
   localparam int FACE_W   = 20;
   localparam int VERT_W   = 20;
   localparam int EDGE_W   = 12;
   localparam int KIND_W   = 2;

   localparam int DEF_MAX_EDGES   = 4096;
   localparam int DEF_TABLE_SLOTS = 8192;
   localparam int DEF_MAX_SHAPES  = 16;
   localparam int DEF_VERTEX_BITS = 20;

   typedef enum logic [KIND_W-1:0] {
      KIND_NEW    = 2'd0,
      KIND_SECOND = 2'd1,
      KIND_FULL   = 2'd2
   } kind_type;
endpackage
`default_nettype wire

/* design/mesh_edge_adjacency_builder.sv */
// Top level: hashed edge table with linear probing on one shared table port.
//
//  channel   ports                                   handshake
//  req       req_shape_index .. req_corner_c         start & !busy
//  rsp       rsp_kind .. rsp_last_of_face            rsp_strobe, one cycle
//
//  A probe of the slot table is a registered read (S_LOOK) then a check (S_CHECK);
//  each edge adds a hash and an advance state (S_HASH, S_NEXT) around its probes,
//  and S_SECOND when its key matches a stored slot. A start is taken while busy is low.
//  After reset a clearing pass sweeps every slot of the table, with busy high.
//  Results leave one per strobe; the receiver cannot stall.
`default_nettype none
module mesh_edge_adjacency_builder #(
   parameter int MAX_EDGES   = meab_pkg::DEF_MAX_EDGES,
   parameter int TABLE_SLOTS = meab_pkg::DEF_TABLE_SLOTS,
   parameter int MAX_SHAPES  = meab_pkg::DEF_MAX_SHAPES,
   parameter int VERTEX_BITS = meab_pkg::DEF_VERTEX_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [meab_pkg::SHAPE_W-1:0]   req_shape_index,
   input  wire logic [meab_pkg::FACE_W-1:0]    req_face_index,
   input  wire logic [meab_pkg::VERT_W-1:0]    req_corner_a,
   input  wire logic [meab_pkg::VERT_W-1:0]    req_corner_b,
   input  wire logic [meab_pkg::VERT_W-1:0]    req_corner_c,
   output logic                                rsp_strobe,
   output logic [meab_pkg::KIND_W-1:0]         rsp_kind,
   output logic [meab_pkg::EDGE_W-1:0]         rsp_edge_number,
   output logic [meab_pkg::VERT_W-1:0]         rsp_end_first,
   output logic [meab_pkg::VERT_W-1:0]         rsp_end_second,
   output logic [meab_pkg::FACE_W-1:0]         rsp_face_out,
   output logic [meab_pkg::SHAPE_W-1:0]        rsp_shape_out,
   output logic [meab_pkg::EDGE_W-1:0]         rsp_local_number,
   output logic                                rsp_last_of_face
);
   import meab_pkg::*;

   localparam int SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int PROBE_W = $clog2(TABLE_SLOTS + 1);
   localparam int EID_W   = $clog2(MAX_EDGES);
   localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
   localparam int SHAPE_N = (MAX_SHAPES < 16) ? MAX_SHAPES : 16;
   localparam int SHP_W   = (SHAPE_N > 1) ? $clog2(SHAPE_N) : 1;
   localparam int HASH_W  = 2 * VERT_W + 2;
   localparam int WORD_W  = 1 + SHAPE_W + 2 * VERT_W + EID_W;
   localparam logic [VERT_W-1:0] VMASK =
      (VERTEX_BITS >= VERT_W) ? {VERT_W{1'b1}} : VERT_W'((64'd1 << VERTEX_BITS) - 64'd1);
   localparam logic [SLOT_W:0] SLOTS_C = (SLOT_W + 1)'(TABLE_SLOTS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_LOOK, S_CHECK, S_SECOND, S_NEXT
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [EDGE_W-1:0]  edge_number;
      logic [VERT_W-1:0]  end_first;
      logic [VERT_W-1:0]  end_second;
      logic [FACE_W-1:0]  face;
      logic [SHAPE_W-1:0] shape;
      logic [EDGE_W-1:0]  local_number;
   } result_type;

   state_type             state_ff;
   logic [SLOT_W-1:0]     pos_ff;
   logic [PROBE_W-1:0]    probes_ff;
   logic [1:0]            edge_ff;
   logic [SHAPE_W-1:0]    shape_ff;
   logic [FACE_W-1:0]     face_ff;
   logic [VERT_W-1:0]     ca_ff, cb_ff, cc_ff;
   logic [EID_W-1:0]      id_ff;
   logic [ECNT_W-1:0]     edges_made_ff;
   logic [ECNT_W-1:0]     shape_cnt_ff [SHAPE_N];
   logic                  pend_valid_ff;
   result_type            pend_ff;
   result_type            rsp_ff;
   logic                  rsp_strobe_ff;
   logic                  rsp_last_ff;

   logic [WORD_W-1:0]     slot_mem [TABLE_SLOTS];
   logic [WORD_W-1:0]     rd_ff;
   logic                  taken_mem [MAX_EDGES];
   logic                  taken_rd_ff;

   logic [VERT_W-1:0]     end_a, end_b, key_lo, key_hi;
   logic [HASH_W-1:0]     hash_full;
   logic [SLOT_W:0]       hash_in;
   logic [SLOT_W-1:0]     hash_pos;
   logic                  rd_valid, rd_match, room;
   logic [SHAPE_W-1:0]    rd_shape;
   logic [VERT_W-1:0]     rd_lo, rd_hi;
   logic [EID_W-1:0]      rd_id, new_id;
   logic [SHP_W-1:0]      shp_idx;
   logic                  mem_we;
   logic [WORD_W-1:0]     mem_wdata;
   logic                  taken_we, taken_wdata;
   logic [EID_W-1:0]      taken_addr;
   logic [SLOT_W:0]       pos_inc;

   always_comb begin
      case (edge_ff)
         2'd0: begin
            end_a = ca_ff;
            end_b = cb_ff;
         end
         2'd1: begin
            end_a = cb_ff;
            end_b = cc_ff;
         end
         default: begin
            end_a = cc_ff;
            end_b = ca_ff;
         end
      endcase
      key_lo    = (end_a < end_b) ? end_a : end_b;
      key_hi    = (end_a < end_b) ? end_b : end_a;
      hash_full = {key_hi, 2'b00} ^ {2'b00, key_lo} ^ {key_lo, 2'b00}
                  ^ HASH_W'({shape_ff, 5'b0});
      hash_in   = (SLOT_W + 1)'(hash_full[SLOT_W-1:0]);
      hash_pos  = (hash_in >= SLOTS_C) ? SLOT_W'(hash_in - SLOTS_C) : SLOT_W'(hash_in);
      pos_inc   = (SLOT_W + 1)'(pos_ff) + 1'b1;
      {rd_valid, rd_shape, rd_lo, rd_hi, rd_id} = rd_ff;
      rd_match  = (rd_shape == shape_ff) && (rd_lo == key_lo) && (rd_hi == key_hi);
      room      = (edges_made_ff < ECNT_W'(MAX_EDGES));
      new_id    = EID_W'(edges_made_ff);
      shp_idx   = SHP_W'(shape_ff);
      mem_we    = (state_ff == S_CLEAR) || (state_ff == S_CHECK && !rd_valid && room);
      mem_wdata = (state_ff == S_CLEAR) ? '0 : {1'b1, shape_ff, key_lo, key_hi, new_id};
      taken_addr  = (state_ff == S_SECOND) ? id_ff : (rd_valid ? rd_id : new_id);
      taken_we    = (state_ff == S_CHECK && !rd_valid && room)
                    || (state_ff == S_SECOND && !taken_rd_ff);
      taken_wdata = (state_ff == S_SECOND);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[pos_ff] <= mem_wdata;
      end
      rd_ff <= slot_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (taken_we) begin
         taken_mem[taken_addr] <= taken_wdata;
      end
      taken_rd_ff <= taken_mem[taken_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         pos_ff        <= '0;
         probes_ff     <= '0;
         edge_ff       <= '0;
         edges_made_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
         for (int i = 0; i < SHAPE_N; i++) begin
            shape_cnt_ff[i] <= '0;
         end
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               pos_ff <= SLOT_W'(pos_inc);
               if (pos_inc == SLOTS_C) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start && (32'(req_shape_index) < MAX_SHAPES)) begin
                  shape_ff <= req_shape_index;
                  face_ff  <= req_face_index;
                  ca_ff    <= req_corner_a & VMASK;
                  cb_ff    <= req_corner_b & VMASK;
                  cc_ff    <= req_corner_c & VMASK;
                  edge_ff  <= '0;
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               pos_ff    <= hash_pos;
               probes_ff <= '0;
               state_ff  <= S_LOOK;
            end
            S_LOOK: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (!rd_valid || probes_ff == PROBE_W'(TABLE_SLOTS - 1)
                   && !rd_match) begin
                  if (!rd_valid && room) begin
                     pend_ff <= '{KIND_NEW, EDGE_W'(new_id), end_a, end_b, face_ff,
                                  shape_ff, EDGE_W'(shape_cnt_ff[shp_idx])};
                     edges_made_ff         <= edges_made_ff + 1'b1;
                     shape_cnt_ff[shp_idx] <= shape_cnt_ff[shp_idx] + 1'b1;
                  end else begin
                     pend_ff <= '{KIND_FULL, '0, end_a, end_b, face_ff, shape_ff, '0};
                  end
                  pend_valid_ff <= 1'b1;
                  if (pend_valid_ff) begin
                     rsp_ff        <= pend_ff;
                     rsp_last_ff   <= 1'b0;
                     rsp_strobe_ff <= 1'b1;
                  end
                  state_ff <= S_NEXT;
               end else if (rd_match) begin
                  id_ff    <= rd_id;
                  state_ff <= S_SECOND;
               end else begin
                  probes_ff <= probes_ff + 1'b1;
                  pos_ff    <= (pos_inc == SLOTS_C) ? '0 : SLOT_W'(pos_inc);
                  state_ff  <= S_LOOK;
               end
            end
            S_SECOND: begin
               if (!taken_rd_ff) begin
                  pend_ff <= '{KIND_SECOND, EDGE_W'(id_ff), end_a, end_b, face_ff,
                               shape_ff, '0};
                  pend_valid_ff <= 1'b1;
                  if (pend_valid_ff) begin
                     rsp_ff        <= pend_ff;
                     rsp_last_ff   <= 1'b0;
                     rsp_strobe_ff <= 1'b1;
                  end
               end
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (edge_ff == 2'd2) begin
                  if (pend_valid_ff) begin
                     rsp_ff        <= pend_ff;
                     rsp_last_ff   <= 1'b1;
                     rsp_strobe_ff <= 1'b1;
                  end
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end else begin
                  edge_ff  <= edge_ff + 1'b1;
                  state_ff <= S_HASH;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_edge_number  = rsp_ff.edge_number;
   assign rsp_end_first    = rsp_ff.end_first;
   assign rsp_end_second   = rsp_ff.end_second;
   assign rsp_face_out     = rsp_ff.face;
   assign rsp_shape_out    = rsp_ff.shape;
   assign rsp_local_number = rsp_ff.local_number;
   assign rsp_last_of_face = rsp_last_ff;

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_kind == KIND_NEW || rsp_kind == KIND_SECOND
                      || rsp_kind == KIND_FULL))
      else $error("illegal result kind");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !pend_valid_ff)
      else $error("pending result left when idle");

   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      edges_made_ff <= ECNT_W'(MAX_EDGES))
      else $error("edge count beyond limit");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (edges_made_ff != $past(edges_made_ff)) |-> $past(state_ff == S_CHECK))
      else $error("edge count moved outside check");
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench for the mesh edge adjacency builder: random and directed triangles, scoreboard check.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import meab_pkg::*;

   localparam int N_EDGES   = DEF_MAX_EDGES;
   localparam int STALL_MAX = 100000;

   typedef struct {
      kind_type          kind;
      logic [EDGE_W-1:0] edge_no;
      logic [VERT_W-1:0] v0;
      logic [VERT_W-1:0] v1;
      logic [FACE_W-1:0] face;
      logic [SHAPE_W-1:0] shape;
      logic [EDGE_W-1:0] local_no;
      logic              last;
   } edge_event_type;

   class edge_table_scoreboard;
      int                  edge_ids [logic [SHAPE_W+2*VERT_W-1:0]];
      bit                  second_taken [N_EDGES];
      int                  shape_counts [16];
      int                  edges_made;
      edge_event_type      pending [$];
      int                  failures;

      task report(string msg);
         $display("mismatch: %s", msg);
         failures++;
      endtask

      function void walk_edge(logic [SHAPE_W-1:0] s, logic [FACE_W-1:0] f,
                              logic [VERT_W-1:0] a, logic [VERT_W-1:0] b);
         logic [SHAPE_W+2*VERT_W-1:0] key;
         edge_event_type ev;
         int id;
         key = (a < b) ? {s, a, b} : {s, b, a};
         ev = '{KIND_FULL, '0, a, b, f, s, '0, 1'b0};
         if (edge_ids.exists(key)) begin
            id = edge_ids[key];
            if (second_taken[id]) return;
            second_taken[id] = 1'b1;
            ev.kind = KIND_SECOND;
            ev.edge_no = EDGE_W'(id);
         end else if (edges_made < N_EDGES) begin
            id = edges_made++;
            edge_ids[key] = id;
            second_taken[id] = 1'b0;
            ev.kind = KIND_NEW;
            ev.edge_no = EDGE_W'(id);
            ev.local_no = EDGE_W'(shape_counts[s]);
            shape_counts[s]++;
         end
         pending = {pending, ev};
      endfunction

      function void note_triangle(logic [SHAPE_W-1:0] s, logic [FACE_W-1:0] f,
                                  logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                                  logic [VERT_W-1:0] c);
         int n0;
         n0 = pending.size();
         walk_edge(s, f, a, b);
         walk_edge(s, f, b, c);
         walk_edge(s, f, c, a);
         if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
      endfunction

      task check(edge_event_type got);
         edge_event_type exp;
         if (pending.size() == 0) begin
            report($sformatf("unexpected transaction kind %0d edge %0d",
                             got.kind, got.edge_no));
            return;
         end
         exp = pending.pop_front();
         if (got.kind !== exp.kind || got.edge_no !== exp.edge_no || got.v0 !== exp.v0 ||
             got.v1 !== exp.v1 || got.face !== exp.face || got.shape !== exp.shape ||
             got.local_no !== exp.local_no || got.last !== exp.last)
            report($sformatf("got %0d/%0d/%h/%h/%h/%h/%0d/%b exp %0d/%0d/%h/%h/%h/%h/%0d/%b",
               got.kind, got.edge_no, got.v0, got.v1, got.face, got.shape, got.local_no,
               got.last, exp.kind, exp.edge_no, exp.v0, exp.v1, exp.face, exp.shape,
               exp.local_no, exp.last));
      endtask
   endclass

   logic clock, reset, start, busy;
   logic [SHAPE_W-1:0] req_shape_index;
   logic [FACE_W-1:0]  req_face_index;
   logic [VERT_W-1:0]  req_corner_a, req_corner_b, req_corner_c;
   logic               rsp_strobe, rsp_last_of_face;
   logic [KIND_W-1:0]  rsp_kind;
   logic [EDGE_W-1:0]  rsp_edge_number, rsp_local_number;
   logic [VERT_W-1:0]  rsp_end_first, rsp_end_second;
   logic [FACE_W-1:0]  rsp_face_out;
   logic [SHAPE_W-1:0] rsp_shape_out;

   edge_table_scoreboard sb = new();
   int stall_cycles = 0;
   bit idling_on;

   mesh_edge_adjacency_builder u_dut (
      .clock, .reset, .start, .busy,
      .req_shape_index, .req_face_index, .req_corner_a, .req_corner_b, .req_corner_c,
      .rsp_strobe, .rsp_kind, .rsp_edge_number, .rsp_end_first, .rsp_end_second,
      .rsp_face_out, .rsp_shape_out, .rsp_local_number, .rsp_last_of_face
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check('{kind_type'(rsp_kind), rsp_edge_number, rsp_end_first, rsp_end_second,
                    rsp_face_out, rsp_shape_out, rsp_local_number, rsp_last_of_face});
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
         $display("mesh_edge_adjacency_builder regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task send_triangle(logic [SHAPE_W-1:0] s, logic [FACE_W-1:0] f,
                      logic [VERT_W-1:0] a, logic [VERT_W-1:0] b, logic [VERT_W-1:0] c);
      start           <= 1'b1;
      req_shape_index <= s;
      req_face_index  <= f;
      req_corner_a    <= a;
      req_corner_b    <= b;
      req_corner_c    <= c;
      do @(posedge clock); while (busy);
      sb.note_triangle(s, f, a, b, c);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   function automatic logic [VERT_W-1:0] pick_corner();
      case ($urandom_range(0, 9))
         0:       return VERT_W'($urandom());
         1:       return {VERT_W{1'b1}} - VERT_W'($urandom_range(0, 3));
         default: return VERT_W'($urandom_range(0, 11));
      endcase
   endfunction

   initial begin
      logic [VERT_W-1:0] a, b, c, vmax;
      logic [SHAPE_W-1:0] s;
      int i;
      vmax = '1;
      start = 1'b0;
      reset = 1'b1;
      req_shape_index = '0;
      req_face_index = '0;
      req_corner_a = '0;
      req_corner_b = '0;
      req_corner_c = '0;
      idling_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_triangle(4'd0, 20'd0, 20'd0, 20'd1, 20'd2);
      send_triangle(4'd0, 20'd1, 20'd2, 20'd1, 20'd0);
      send_triangle(4'd0, 20'd2, 20'd0, 20'd1, 20'd2);
      send_triangle(4'd15, vmax, vmax, 20'd0, vmax - 1);
      send_triangle(4'd15, 20'h5A5A5, vmax - 1, vmax, 20'd0);
      send_triangle(4'd3, 20'd7, 20'd5, 20'd5, 20'd5);
      send_triangle(4'd3, 20'd8, 20'd5, 20'd5, 20'd6);
      send_triangle(4'd3, 20'd9, 20'd6, 20'd5, 20'd6);
      send_triangle(4'd1, 20'hAAAAA, 20'h55555, 20'hAAAAA, 20'h0F0F0);
      send_triangle(4'd1, 20'h55555, 20'h0F0F0, 20'h55555, 20'hF0F0F);
      send_triangle(4'd2, 20'd3, 20'd0, 20'd1, 20'd2);

      for (i = 0; i < 240; i++) begin
         s = SHAPE_W'($urandom_range(0, 15));
         a = pick_corner();
         b = pick_corner();
         c = ($urandom_range(0, 9) == 0) ? a : pick_corner();
         if (i > 190) idling_on = 1'b0;
         send_triangle(s, FACE_W'($urandom()), a, b, c);
      end

      for (i = 0; i < 8; i++) begin
         send_triangle(i[3:0], FACE_W'(20'hFFF00 + i), VERT_W'(1000 + 3 * i),
                       VERT_W'(1001 + 3 * i), VERT_W'(900000 + i));
      end
      start <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("mesh_edge_adjacency_builder regression: pass");
      end else begin
         $display("mesh_edge_adjacency_builder regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
design/meab_pkg.sv
design/mesh_edge_adjacency_builder.sv
verif/tb_top.sv
